FILE: hdl/nlfa_pkg.sv
// Shared types, constants and helpers for the node link force accumulator.
// No dependencies; every other file but nlfa_checker imports this package.
package nlfa_pkg;

    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;

    // exp(-1) and exp(-1/16) in Q2.30, and Q2.30 one and one half
    localparam logic [31:0] EXP_M1    = 32'd395007542;
    localparam logic [31:0] EXP_M16   = 32'd1008687096;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [63:0] Q30_HALF  = 64'h0000_0000_2000_0000;
    localparam logic [63:0] EXP_LIMIT = 64'd22;

    typedef logic [NUM_CFG-1:0][31:0] t_cfg_bank;

    // one link as it waits between front and back
    typedef struct packed {
        logic [2:0][31:0] self_pos;
        logic [2:0][31:0] dmag;
        logic [2:0]       dneg;
        logic             kind;
        logic             valid;
        logic             first;
        logic             last;
        logic [31:0]      dt;
    } t_link;

    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0][31:0] pos;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    // clamp a signed value to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/nlfa_front.sv
// Front end: takes a link request and forms the saturated per-axis offset.
// Depends on nlfa_pkg.
module nlfa_front (
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic [31:0]           i_self_x,
    input  logic [31:0]           i_self_y,
    input  logic [31:0]           i_self_z,
    input  logic [31:0]           i_other_x,
    input  logic [31:0]           i_other_y,
    input  logic [31:0]           i_other_z,
    input  logic                  i_link_kind,
    input  logic                  i_link_valid,
    input  logic                  i_first_link,
    input  logic                  i_last_link,
    input  logic [31:0]           i_time_step,
    output logic                  o_wr,
    output nlfa_pkg::t_link       o_link
);
    import nlfa_pkg::*;

    logic [2:0][31:0] self_v;
    logic [2:0][31:0] other_v;
    logic [2:0][31:0] d_sat;

    assign self_v  = {i_self_z, i_self_y, i_self_x};
    assign other_v = {i_other_z, i_other_y, i_other_x};

    // saturate the offset and split it into sign and magnitude
    always_comb begin
        o_link = '0;
        for (int a = 0; a < 3; a++) begin
            d_sat[a] = sat32(64'($signed(self_v[a])) - 64'($signed(other_v[a])));
            o_link.dneg[a] = d_sat[a][31];
            o_link.dmag[a] = d_sat[a][31] ? 32'(-d_sat[a]) : d_sat[a];
        end
        o_link.self_pos = self_v;
        o_link.kind     = i_link_kind;
        o_link.valid    = i_link_valid;
        o_link.first    = i_first_link;
        o_link.last     = i_last_link;
        o_link.dt       = i_time_step;
    end

    assign o_wr = i_push && !i_full;

endmodule

FILE: hdl/nlfa_queue.sv
// Two-entry request queue between front and back.
// Depends on nlfa_pkg.
module nlfa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  nlfa_pkg::t_link i_data,
    output logic            o_full,
    output logic            o_valid,
    output nlfa_pkg::t_link o_data,
    input  logic            i_rd
);
    import nlfa_pkg::*;

    t_link      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    // store incoming requests
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (i_rd) begin
                r_rptr <= ~r_rptr;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 2'd1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/nlfa_divider.sv
// Shared restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on nlfa_pkg.
module nlfa_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nlfa_pkg::t_div_req i_req,
    output nlfa_pkg::t_div_rsp o_rsp
);
    import nlfa_pkg::*;

    logic [63:0] r_dvd;
    logic [31:0] r_dvs;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_dvd[63]};
    assign ge     = (rem_sh >= {1'b0, r_dvs});

    // shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
            r_dvd <= {r_dvd[62:0], ge};
        end
    end

    // track the step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;

endmodule

FILE: hdl/nlfa_back.sv
// Back end sequencer: length, decay terms, force accumulation and move.
// Depends on nlfa_pkg; drives the shared nlfa_divider.
module nlfa_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nlfa_pkg::t_cfg_bank i_cfg,
    input  logic                i_q_valid,
    input  nlfa_pkg::t_link     i_q_data,
    output logic                o_q_pop,
    output nlfa_pkg::t_div_req  o_div_req,
    input  nlfa_pkg::t_div_rsp  i_div_rsp,
    output logic                o_res_valid,
    input  logic                i_res_pop,
    output nlfa_pkg::t_result   o_res
);
    import nlfa_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQ    = 5'd1;
    localparam logic [4:0] S_SQA   = 5'd2;
    localparam logic [4:0] S_SQRT  = 5'd3;
    localparam logic [4:0] S_LEN   = 5'd4;
    localparam logic [4:0] S_TSEL  = 5'd5;
    localparam logic [4:0] S_DIVC  = 5'd6;
    localparam logic [4:0] S_DIVX  = 5'd7;
    localparam logic [4:0] S_EXPN  = 5'd8;
    localparam logic [4:0] S_EXPR  = 5'd9;
    localparam logic [4:0] S_TERM  = 5'd10;
    localparam logic [4:0] S_TACC  = 5'd11;
    localparam logic [4:0] S_FORCE = 5'd12;
    localparam logic [4:0] S_AXM   = 5'd13;
    localparam logic [4:0] S_AXD   = 5'd14;
    localparam logic [4:0] S_AXW   = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;
    localparam logic [4:0] S_MVM   = 5'd17;
    localparam logic [4:0] S_MVA   = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    localparam logic [1:0] PH_E1   = 2'd0;
    localparam logic [1:0] PH_E16  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    logic [4:0]       r_state;
    t_link            r_item;
    logic [2:0][31:0] r_acc;
    logic [2:0][31:0] r_new;
    logic [63:0]      r_prod;
    logic [1:0]       r_axis;
    logic [63:0]      r_rad;
    logic [31:0]      r_root;
    logic [32:0]      r_rem;
    logic [4:0]       r_cnt;
    logic             r_term;
    logic [31:0]      r_c;
    logic [30:0]      r_v;
    logic [3:0]       r_j;
    logic [30:0]      r_rsh;
    logic [1:0]       r_ph;
    logic [31:0]      r_rep;
    logic [31:0]      r_att;
    logic [31:0]      r_fmag;
    logic             r_fneg;
    logic             r_out_valid;
    t_result          r_out;

    logic [31:0] amp;
    logic [31:0] rng;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        sq_ge;
    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] acc_mag;
    logic [32:0] fdiff;
    logic [63:0] qv;
    logic [63:0] pv;
    logic        emit_ok;

    // register pair for the current term: amplitude then range
    assign amp = i_cfg[{r_item.kind, 1'b0, r_term}];
    assign rng = i_cfg[{r_item.kind, 1'b1, r_term}];

    // square root step: two radicand bits per cycle
    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    assign acc_mag = r_acc[r_axis][31] ? 32'(-r_acc[r_axis]) : r_acc[r_axis];
    assign fdiff   = {1'b0, r_rep} - {1'b0, r_att};
    assign qv      = {31'd0, i_div_rsp.quot[32:0]};
    assign pv      = r_prod >> FRAC_BITS;
    assign emit_ok = !r_out_valid || i_res_pop;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // select operands for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_SQ: begin
                mul_en = 1'b1;
                mul_a  = r_item.dmag[r_axis];
                mul_b  = r_item.dmag[r_axis];
            end
            S_EXPN: begin
                mul_a = 32'(r_v);
                if (r_ph == PH_E1 && r_cnt != 5'd0) begin
                    mul_en = 1'b1;
                    mul_b  = EXP_M1;
                end else if (r_ph == PH_E16 && r_cnt != 5'd0) begin
                    mul_en = 1'b1;
                    mul_b  = EXP_M16;
                end else if (r_ph == PH_FRAC) begin
                    mul_en = 1'b1;
                    mul_b  = 32'(Q30_ONE - r_rsh);
                end
            end
            S_TERM: begin
                mul_en = 1'b1;
                mul_a  = r_c;
                mul_b  = 32'(r_v);
            end
            S_AXM: begin
                mul_en = 1'b1;
                mul_a  = r_fmag;
                mul_b  = r_item.dmag[r_axis];
            end
            S_MVM: begin
                mul_en = 1'b1;
                mul_a  = acc_mag;
                mul_b  = r_item.dt;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // launch divisions
    always_comb begin
        o_div_req = '0;
        case (r_state)
            S_TSEL: begin
                if (amp != 32'd0 && rng != 32'd0) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = 64'(amp) << FRAC_BITS;
                    o_div_req.divisor  = rng;
                end
            end
            S_DIVC: begin
                if (i_div_rsp.done) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = 64'(r_root) << FRAC_BITS;
                    o_div_req.divisor  = rng;
                end
            end
            S_AXD: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = r_prod;
                o_div_req.divisor  = r_root;
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
    end

    // datapath registers stepped by the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_item <= i_q_data;
                    r_axis <= 2'd0;
                    r_rad  <= '0;
                end
            end
            S_SQA: begin
                r_rad <= r_rad + r_prod;
                if (r_axis == 2'd2) begin
                    r_root <= '0;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_axis <= r_axis + 2'd1;
                end
            end
            S_SQRT: begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= sq_ge ? 33'(rem_sh - trial) : 33'(rem_sh);
                r_root <= {r_root[30:0], sq_ge};
                r_cnt  <= r_cnt + 5'd1;
            end
            S_LEN: begin
                r_term <= 1'b0;
            end
            S_TSEL: begin
                if (amp == 32'd0 || rng == 32'd0) begin
                    if (r_term) begin
                        r_att <= '0;
                    end else begin
                        r_rep  <= '0;
                        r_term <= 1'b1;
                    end
                end
            end
            S_DIVC: begin
                if (i_div_rsp.done) begin
                    r_c <= (i_div_rsp.quot[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                            : i_div_rsp.quot[31:0];
                end
            end
            S_DIVX: begin
                if (i_div_rsp.done) begin
                    if ((i_div_rsp.quot >> FRAC_BITS) >= EXP_LIMIT) begin
                        r_v <= '0;
                    end else begin
                        r_v   <= Q30_ONE;
                        r_ph  <= PH_E1;
                        r_cnt <= 5'(i_div_rsp.quot >> FRAC_BITS);
                        r_j   <= i_div_rsp.quot[FRAC_BITS-1 -: 4];
                        r_rsh <= 31'(i_div_rsp.quot[FRAC_BITS-5:0]) << (30 - FRAC_BITS);
                    end
                end
            end
            S_EXPN: begin
                if (r_ph == PH_E1) begin
                    if (r_cnt != 5'd0) begin
                        r_cnt <= r_cnt - 5'd1;
                    end else begin
                        r_ph  <= PH_E16;
                        r_cnt <= 5'(r_j);
                    end
                end else if (r_ph == PH_E16) begin
                    if (r_cnt != 5'd0) begin
                        r_cnt <= r_cnt - 5'd1;
                    end else begin
                        r_ph <= PH_FRAC;
                    end
                end else begin
                    r_ph <= PH_END;
                end
            end
            S_EXPR: begin
                r_v <= 31'((r_prod + Q30_HALF) >> 30);
            end
            S_TACC: begin
                if (r_term) begin
                    r_att <= r_prod[61:30];
                end else begin
                    r_rep  <= r_prod[61:30];
                    r_term <= 1'b1;
                end
            end
            S_FORCE: begin
                r_axis <= 2'd0;
                if (fdiff[32] && r_item.kind) begin
                    r_fmag <= '0;
                    r_fneg <= 1'b0;
                end else begin
                    r_fneg <= fdiff[32];
                    r_fmag <= fdiff[32] ? 32'(-fdiff) : fdiff[31:0];
                end
            end
            S_AXW: begin
                if (i_div_rsp.done) begin
                    r_axis <= r_axis + 2'd1;
                end
            end
            S_DONE: begin
                r_axis <= 2'd0;
            end
            S_MVA: begin
                r_new[r_axis] <= sat32(64'($signed(r_item.self_pos[r_axis]))
                                       + (r_acc[r_axis][31] ? -pv : pv));
                r_axis <= r_axis + 2'd1;
            end
            default: begin
                r_axis <= r_axis;
            end
        endcase
    end

    // sequence states, accumulator and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_res_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_data.first) begin
                            r_acc <= '0;
                        end
                        r_state <= i_q_data.valid ? S_SQ : S_DONE;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQA;
                end
                S_SQA: begin
                    r_state <= (r_axis == 2'd2) ? S_SQRT : S_SQ;
                end
                S_SQRT: begin
                    if (r_cnt == 5'd31) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_state <= (r_root == 32'd0) ? S_DONE : S_TSEL;
                end
                S_TSEL: begin
                    if (amp != 32'd0 && rng != 32'd0) begin
                        r_state <= S_DIVC;
                    end else if (r_term) begin
                        r_state <= S_FORCE;
                    end
                end
                S_DIVC: begin
                    if (i_div_rsp.done) begin
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (i_div_rsp.done) begin
                        if ((i_div_rsp.quot >> FRAC_BITS) >= EXP_LIMIT) begin
                            r_state <= S_TERM;
                        end else begin
                            r_state <= S_EXPN;
                        end
                    end
                end
                S_EXPN: begin
                    if (mul_en) begin
                        r_state <= S_EXPR;
                    end
                end
                S_EXPR: begin
                    r_state <= (r_ph == PH_END) ? S_TERM : S_EXPN;
                end
                S_TERM: begin
                    r_state <= S_TACC;
                end
                S_TACC: begin
                    r_state <= r_term ? S_FORCE : S_TSEL;
                end
                S_FORCE: begin
                    r_state <= S_AXM;
                end
                S_AXM: begin
                    r_state <= S_AXD;
                end
                S_AXD: begin
                    r_state <= S_AXW;
                end
                S_AXW: begin
                    if (i_div_rsp.done) begin
                        r_acc[r_axis] <= sat32(64'($signed(r_acc[r_axis]))
                            + ((r_fneg != r_item.dneg[r_axis]) ? -qv : qv));
                        r_state <= (r_axis == 2'd2) ? S_DONE : S_AXM;
                    end
                end
                S_DONE: begin
                    r_state <= r_item.last ? S_MVM : S_IDLE;
                end
                S_MVM: begin
                    r_state <= S_MVA;
                end
                S_MVA: begin
                    r_state <= (r_axis == 2'd2) ? S_EMIT : S_MVM;
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // hold the finished result until it is taken
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_ok) begin
            r_out.vel <= r_acc;
            r_out.pos <= r_new;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

FILE: hdl/node_link_force_accumulate_unit.sv
// Top level of the node link force accumulator: configuration bank and wiring.
// Depends on nlfa_pkg, nlfa_front, nlfa_queue, nlfa_divider and nlfa_back.
//
// Each request carries one neighbour link of a node; a request with the last
// flag set produces one result (velocity and moved position), others none.
// Requests wait in a two-entry queue, and a finished result waits in an output
// register, so pushes continue while a result is not yet popped. In the back
// end an invalid link goes straight to the end of the link, a valid link of
// zero length stops after the sum of squares and the square root, and a last
// link adds the move. A contributing link also waits up to seven times on the
// shared one-bit-per-cycle divider and runs an exponential of up to 37
// multiply steps per term on the single shared 32x32 multiplier. The config
// channel is always ready; write registers only while the block is idle.
module node_link_force_accumulate_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [31:0]                    i_self_x,
    input  logic [31:0]                    i_self_y,
    input  logic [31:0]                    i_self_z,
    input  logic [31:0]                    i_other_x,
    input  logic [31:0]                    i_other_y,
    input  logic [31:0]                    i_other_z,
    input  logic                           i_link_kind,
    input  logic                           i_link_valid,
    input  logic                           i_first_link,
    input  logic                           i_last_link,
    input  logic [31:0]                    i_time_step,
    output logic                           empty,
    input  logic                           pop,
    output logic [31:0]                    o_vel_x,
    output logic [31:0]                    o_vel_y,
    output logic [31:0]                    o_vel_z,
    output logic [31:0]                    o_new_x,
    output logic [31:0]                    o_new_y,
    output logic [31:0]                    o_new_z,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nlfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import nlfa_pkg::*;

    t_cfg_bank r_cfg;
    t_link     front_link;
    t_link     q_data;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_result   res;
    logic      front_wr;
    logic      q_valid;
    logic      q_pop;
    logic      res_valid;

    // configuration bank, reset to unity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= 32'(64'd1 << FRAC_BITS);
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    nlfa_front u_front (
        .i_push       (push),
        .i_full       (full),
        .i_self_x     (i_self_x),
        .i_self_y     (i_self_y),
        .i_self_z     (i_self_z),
        .i_other_x    (i_other_x),
        .i_other_y    (i_other_y),
        .i_other_z    (i_other_z),
        .i_link_kind  (i_link_kind),
        .i_link_valid (i_link_valid),
        .i_first_link (i_first_link),
        .i_last_link  (i_last_link),
        .i_time_step  (i_time_step),
        .o_wr         (front_wr),
        .o_link       (front_link)
    );

    nlfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (front_link),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_rd    (q_pop)
    );

    nlfa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    nlfa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_res_valid (res_valid),
        .i_res_pop   (pop),
        .o_res       (res)
    );

    assign empty   = !res_valid;
    assign o_vel_x = res.vel[0];
    assign o_vel_y = res.vel[1];
    assign o_vel_z = res.vel[2];
    assign o_new_x = res.pos[0];
    assign o_new_y = res.pos[1];
    assign o_new_z = res.pos[2];

endmodule

FILE: hdl/nlfa_checker.sv
// Port-level checks for the node link force accumulator, bound to the top.
// Depends on node_link_force_accumulate_unit.
module nlfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_vel_x,
    input logic [31:0] o_new_x
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // reset leaves the request queue with room
    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("request queue full after reset");

    // hold a waiting result until it is popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_vel_x) && $stable(o_new_x)))
        else $error("waiting result changed or vanished");

endmodule

bind node_link_force_accumulate_unit nlfa_checker u_nlfa_checker (.*);
